FILE: design/vector_angle_3d_macros.svh
// Assertion macros for the vector_angle_3d block.
// Used by the top level only; no other dependencies.
`ifndef VECTOR_ANGLE_3D_MACROS_SVH
`define VECTOR_ANGLE_3D_MACROS_SVH

// same-cycle implication
`define VANG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VANG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/vang_pkg.sv
// Shared constants, types and the arctangent table for vector_angle_3d.
// No dependencies.
package vang_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int ANGLE_FRAC_DEF  = 16;

  localparam int NORM_BITS    = 30;              // normalized magnitude width
  localparam int Z_FRAC       = 30;              // angle accumulator fraction bits
  localparam int CORDIC_STEPS = 30;
  localparam int Z_W          = 34;              // signed angle accumulator
  localparam int X_W          = NORM_BITS + 5;   // signed CORDIC x/y, gain headroom
  localparam int SQ_W         = 2 * NORM_BITS + 2;
  localparam int SR_W         = NORM_BITS + 1;   // square root width

  localparam logic signed [Z_W-1:0] PI_Z      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Z = 34'sd1686629713;

  typedef struct packed {
    logic valid;
    logic zero_len;   // a or b is the zero vector
    logic null_out;   // force angle to 0
    logic dneg;       // dot product negative
  } ctl_t;

  // atan(2^-k) in radians, Z_FRAC fraction bits, rounded
  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned k);
    case (k)
      0:       atan_entry = 34'sd843314857;
      1:       atan_entry = 34'sd497837829;
      2:       atan_entry = 34'sd263043837;
      3:       atan_entry = 34'sd133525159;
      4:       atan_entry = 34'sd67021687;
      5:       atan_entry = 34'sd33543516;
      6:       atan_entry = 34'sd16775851;
      7:       atan_entry = 34'sd8388437;
      8:       atan_entry = 34'sd4194283;
      9:       atan_entry = 34'sd2097149;
      default: atan_entry = $signed(Z_W'(64'd1 << (Z_FRAC - k)));
    endcase
  endfunction

endpackage

FILE: design/vang_prod.sv
// Products stage: nine coordinate products, then dot magnitude/sign and
// cross-product magnitudes. Depends on vang_pkg.
module vang_prod #(
  parameter int COORD_WIDTH = vang_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [COORD_WIDTH-1:0]     a_x_i,
  input  logic signed [COORD_WIDTH-1:0]     a_y_i,
  input  logic signed [COORD_WIDTH-1:0]     a_z_i,
  input  logic signed [COORD_WIDTH-1:0]     b_x_i,
  input  logic signed [COORD_WIDTH-1:0]     b_y_i,
  input  logic signed [COORD_WIDTH-1:0]     b_z_i,
  output vang_pkg::ctl_t                    ctl_o,
  output logic [3:0][2*COORD_WIDTH-1:0]     mag_o
);

  localparam int PW = 2 * COORD_WIDTH;
  localparam int DW = PW + 2;

  logic signed [PW-1:0] prod_d [9];
  logic signed [PW-1:0] prod_q [9];
  vang_pkg::ctl_t       ctl_a_d, ctl_a_q, ctl_b_d, ctl_b_q;
  logic                 za, zb;

  assign prod_d[0] = a_x_i * b_x_i;
  assign prod_d[1] = a_y_i * b_y_i;
  assign prod_d[2] = a_z_i * b_z_i;
  assign prod_d[3] = a_y_i * b_z_i;
  assign prod_d[4] = a_z_i * b_y_i;
  assign prod_d[5] = a_z_i * b_x_i;
  assign prod_d[6] = a_x_i * b_z_i;
  assign prod_d[7] = a_x_i * b_y_i;
  assign prod_d[8] = a_y_i * b_x_i;

  assign za = ((a_x_i | a_y_i | a_z_i) == '0);
  assign zb = ((b_x_i | b_y_i | b_z_i) == '0);

  always_comb begin
    ctl_a_d.valid    = valid_i;
    ctl_a_d.zero_len = za | zb;
    ctl_a_d.null_out = za | zb;
    ctl_a_d.dneg     = 1'b0;
  end

  // second stage: dot sum and cross differences
  logic signed [DW-1:0]   dot;
  logic signed [PW:0]     cr [3];
  logic [PW-1:0]          mag_d [4];
  logic [PW-1:0]          mag_q [4];

  always_comb begin
    dot = DW'(prod_q[0]) + DW'(prod_q[1]) + DW'(prod_q[2]);
    cr[0] = (PW+1)'(prod_q[3]) - (PW+1)'(prod_q[4]);
    cr[1] = (PW+1)'(prod_q[5]) - (PW+1)'(prod_q[6]);
    cr[2] = (PW+1)'(prod_q[7]) - (PW+1)'(prod_q[8]);
    mag_d[0] = dot[DW-1] ? PW'(-dot) : PW'(dot);
    for (int j = 0; j < 3; j++) begin
      mag_d[j+1] = cr[j][PW] ? PW'(-cr[j]) : PW'(cr[j]);
    end
    ctl_b_d      = ctl_a_q;
    ctl_b_d.dneg = dot[DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      mag_q  <= mag_d;
    end
  end

  assign ctl_o = ctl_b_q;
  always_comb begin
    for (int j = 0; j < 4; j++) mag_o[j] = mag_q[j];
  end

endmodule

FILE: design/vang_norm.sv
// Normalization: leading-one search, common shift to NORM_BITS, squares and
// their sum. Depends on vang_pkg.
module vang_norm #(
  parameter int COORD_WIDTH = vang_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  vang_pkg::ctl_t                     ctl_i,
  input  logic [3:0][2*COORD_WIDTH-1:0]      mag_i,
  output vang_pkg::ctl_t                     ctl_o,
  output logic [vang_pkg::NORM_BITS-1:0]     v0_o,
  output logic [vang_pkg::SQ_W-1:0]          sq_o
);

  localparam int PW = 2 * COORD_WIDTH;
  localparam int PB = $clog2(PW);
  localparam int NB = vang_pkg::NORM_BITS;
  localparam int WW = PW + NB - 1;

  vang_pkg::ctl_t ctl_c_d, ctl_c_q, ctl_d_q, ctl_e_q, ctl_f_q;

  // stage C: position of the leading one of the largest magnitude
  logic [PW-1:0]  orv;
  logic [PB-1:0]  msb_d, msb_q;
  logic [PW-1:0]  mag_c_q [4];

  always_comb begin
    orv   = mag_i[0] | mag_i[1] | mag_i[2] | mag_i[3];
    msb_d = '0;
    for (int i = 0; i < PW; i++) begin
      if (orv[i]) msb_d = PB'(i);
    end
    ctl_c_d = ctl_i;
    if (orv == '0) ctl_c_d.null_out = 1'b1;
  end

  // stage D: shift so the leading one lands on bit NB-1 (truncating)
  logic [WW-1:0]  shw [4];
  logic [NB-1:0]  nv_d [4];
  logic [NB-1:0]  nv_q [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      shw[j]  = {mag_c_q[j], (NB-1)'(0)} >> msb_q;
      nv_d[j] = shw[j][NB-1:0];
    end
  end

  // stage E: squares of the cross components
  logic [2*NB-1:0] sqp_q [3];
  logic [NB-1:0]   v0_e_q;
  // stage F: sum
  logic [vang_pkg::SQ_W-1:0] sq_q;
  logic [NB-1:0]             v0_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
      ctl_d_q <= '0;
      ctl_e_q <= '0;
      ctl_f_q <= '0;
    end else if (en_i) begin
      ctl_c_q <= ctl_c_d;
      ctl_d_q <= ctl_c_q;
      ctl_e_q <= ctl_d_q;
      ctl_f_q <= ctl_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      msb_q <= msb_d;
      for (int j = 0; j < 4; j++) mag_c_q[j] <= mag_i[j];
      nv_q  <= nv_d;
      for (int j = 0; j < 3; j++) sqp_q[j] <= nv_q[j+1] * nv_q[j+1];
      v0_e_q <= nv_q[0];
      sq_q   <= vang_pkg::SQ_W'(sqp_q[0]) + vang_pkg::SQ_W'(sqp_q[1])
              + vang_pkg::SQ_W'(sqp_q[2]);
      v0_f_q <= v0_e_q;
    end
  end

  assign ctl_o = ctl_f_q;
  assign v0_o  = v0_f_q;
  assign sq_o  = sq_q;

endmodule

FILE: design/vang_sqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on vang_pkg.
module vang_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  vang_pkg::ctl_t                   ctl_i,
  input  logic [vang_pkg::NORM_BITS-1:0]   v0_i,
  input  logic [vang_pkg::SQ_W-1:0]        sq_i,
  output vang_pkg::ctl_t                   ctl_o,
  output logic [vang_pkg::NORM_BITS-1:0]   v0_o,
  output logic [vang_pkg::SR_W-1:0]        root_o
);

  localparam int SW = vang_pkg::SQ_W;
  localparam int NS = vang_pkg::SR_W;
  localparam int NB = vang_pkg::NORM_BITS;

  logic [SW-1:0]  n_q   [NS];
  logic [SW-1:0]  r_q   [NS];
  logic [NB-1:0]  v0_q  [NS];
  vang_pkg::ctl_t ctl_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (NS - 1 - k));
    logic [SW-1:0]  n_cur, r_cur, trial, n_d, r_d;
    logic [NB-1:0]  v0_cur;
    vang_pkg::ctl_t ctl_cur;

    if (k == 0) begin : g_first
      assign n_cur   = sq_i;
      assign r_cur   = '0;
      assign v0_cur  = v0_i;
      assign ctl_cur = ctl_i;
    end else begin : g_next
      assign n_cur   = n_q[k-1];
      assign r_cur   = r_q[k-1];
      assign v0_cur  = v0_q[k-1];
      assign ctl_cur = ctl_q[k-1];
    end

    always_comb begin
      trial = r_cur + BIT;
      if (n_cur >= trial) begin
        n_d = n_cur - trial;
        r_d = (r_cur >> 1) + BIT;
      end else begin
        n_d = n_cur;
        r_d = r_cur >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_cur;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]  <= n_d;
        r_q[k]  <= r_d;
        v0_q[k] <= v0_cur;
      end
    end
  end

  assign ctl_o  = ctl_q[NS-1];
  assign v0_o   = v0_q[NS-1];
  assign root_o = r_q[NS-1][NS-1:0];

endmodule

FILE: design/vang_cordic.sv
// Vectoring CORDIC, one rotation per stage, then clamp to [0, pi] and
// rounding into the output register. Depends on vang_pkg.
module vang_cordic #(
  parameter int ANGLE_FRAC_BITS = vang_pkg::ANGLE_FRAC_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  vang_pkg::ctl_t                   ctl_i,
  input  logic [vang_pkg::NORM_BITS-1:0]   v0_i,
  input  logic [vang_pkg::SR_W-1:0]        root_i,
  output logic                             valid_o,
  output logic [ANGLE_FRAC_BITS+1:0]       angle_o,
  output logic                             zero_length_o
);

  localparam int XW = vang_pkg::X_W;
  localparam int ZW = vang_pkg::Z_W;
  localparam int NS = vang_pkg::CORDIC_STEPS;
  localparam int AW = ANGLE_FRAC_BITS + 2;
  localparam int SH = vang_pkg::Z_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ZW-1:0] RND = ZW'(1) << (SH - 1);

  logic signed [XW-1:0] x_q [NS+1];
  logic signed [XW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];
  vang_pkg::ctl_t       ctl_q [NS+1];

  // entry: negative dot product starts pre-rotated by pi/2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ctl_i.dneg) begin
        x_q[0] <= $signed(XW'(root_i));
        y_q[0] <= $signed(XW'(v0_i));
        z_q[0] <= vang_pkg::HALF_PI_Z;
      end else begin
        x_q[0] <= $signed(XW'(v0_i));
        y_q[0] <= $signed(XW'(root_i));
        z_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN = vang_pkg::atan_entry(k);
    logic signed [XW-1:0] xs, ys;

    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[k][XW-1]) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + ATAN;
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - ATAN;
        end
      end
    end
  end

  // clamp and round half up
  logic [ZW-1:0] zc, zr;
  logic [AW-1:0] angle_d, angle_q;
  logic          valid_q, zero_q;

  always_comb begin
    if (z_q[NS][ZW-1]) begin
      zc = '0;
    end else if (z_q[NS] > vang_pkg::PI_Z) begin
      zc = vang_pkg::PI_Z;
    end else begin
      zc = z_q[NS];
    end
    zr      = (zc + RND) >> SH;
    angle_d = ctl_q[NS].null_out ? '0 : zr[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_q[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
      zero_q  <= ctl_q[NS].zero_len;
    end
  end

  assign valid_o       = valid_q;
  assign angle_o       = angle_q;
  assign zero_length_o = zero_q;

endmodule

FILE: design/vector_angle_3d.sv
// Pipeline: product, normalize, square-root and CORDIC stages, plus the CORDIC
//   entry and output registers.
// Throughput: one vector pair per cycle; every stage is a register, the
//   pipeline holds as a whole only while a finished result is stalled.
// Reset: rst_ni asynchronous, active low; clears the stage control bits and output valid only.
`include "vector_angle_3d_macros.svh"

module vector_angle_3d #(
  parameter int COORD_WIDTH     = vang_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = vang_pkg::ANGLE_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_z_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_z_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ANGLE_FRAC_BITS+1:0]    angle_o,
  output logic                          zero_length_o
);

  localparam int PW = 2 * COORD_WIDTH;
  localparam int AW = ANGLE_FRAC_BITS + 2;
  localparam int SH = vang_pkg::Z_FRAC - ANGLE_FRAC_BITS;
  // pi after rounding: the largest angle the block can report
  localparam logic [AW-1:0] ANGLE_MAX =
    AW'((vang_pkg::PI_Z + (vang_pkg::Z_W'(1) << (SH - 1))) >> SH);

  // The whole pipeline moves together; it freezes only when the output
  // register holds a result that the sink is not taking.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  vang_pkg::ctl_t         prod_ctl, norm_ctl, sqrt_ctl;
  logic [3:0][PW-1:0]     prod_mag;
  logic [vang_pkg::NORM_BITS-1:0] norm_v0, sqrt_v0;
  logic [vang_pkg::SQ_W-1:0]      norm_sq;
  logic [vang_pkg::SR_W-1:0]      sqrt_root;

  // products, exact dot product and cross-product magnitudes
  vang_prod #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .a_z_i   (a_z_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .b_z_i   (b_z_i),
    .ctl_o   (prod_ctl),
    .mag_o   (prod_mag)
  );

  // common scaling to 30 bits and |a x b| squared
  vang_norm #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (prod_ctl),
    .mag_i  (prod_mag),
    .ctl_o  (norm_ctl),
    .v0_o   (norm_v0),
    .sq_o   (norm_sq)
  );

  // |a x b| as floor square root
  vang_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (norm_ctl),
    .v0_i   (norm_v0),
    .sq_i   (norm_sq),
    .ctl_o  (sqrt_ctl),
    .v0_o   (sqrt_v0),
    .root_o (sqrt_root)
  );

  // atan2(|a x b|, a.b) and output register
  vang_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .ctl_i         (sqrt_ctl),
    .v0_i          (sqrt_v0),
    .root_i        (sqrt_root),
    .valid_o       (out_valid_o),
    .angle_o       (angle_o),
    .zero_length_o (zero_length_o)
  );

  // a zero-length vector always reports angle 0
  `VANG_ASSERT_NOW(a_zero_angle, clk_i, rst_ni, out_valid_o && zero_length_o, angle_o == '0, "zero_length with nonzero angle")
  // clamp keeps the angle within [0, pi]
  `VANG_ASSERT_NOW(a_angle_max, clk_i, rst_ni, out_valid_o, angle_o <= ANGLE_MAX, "angle above pi")
  // input is held back only by a stalled result
  `VANG_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output stall")
  // an accepted pair enters the first stage
  `VANG_ASSERT_NEXT(a_first_stage, clk_i, rst_ni, in_valid_i && !in_stall_o, u_prod.ctl_a_q.valid, "accepted pair lost at entry")

endmodule

FILE: tb/vector_angle_3d_test.sv
// Self-checking testbench for vector_angle_3d: random and directed vector pairs.
// Depends on design/vang_pkg.sv and design/vector_angle_3d.sv.
module vector_angle_3d_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW      = vang_pkg::COORD_WIDTH_DEF;
  localparam int AFB     = vang_pkg::ANGLE_FRAC_DEF;
  localparam int N_RAND  = 900;
  localparam int LIMIT   = 400000;
  localparam int DRAIN   = 150;     // well past the pipeline depth
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct {
    logic [AFB+1:0] angle;
    logic           zero_len;
  } angle_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic out_valid, out_stall;
  logic [AFB+1:0] angle;
  logic zero_length;

  vector_angle_3d dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .angle_o(angle), .zero_length_o(zero_length)
  );

  pair_t  pair_q[$];      // pairs waiting to be driven
  angle_t angle_exp_q[$]; // predicted angles, oldest first
  int     n_sent, n_total, n_mismatch, cycles;
  bit     calm;           // final stretch: no idling on either side

  // arctangent table, built from Machin's formula and the arctangent series
  longint signed atan_z[30];
  longint signed pi_z, half_pi_z;

  function automatic longint unsigned round_z(longint unsigned v);
    return (v + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned atan_recip(longint unsigned m);
    longint unsigned t, sum, m2, term;
    int unsigned k;
    t = (64'd1 << 60) / m; sum = 0; m2 = m * m; k = 0;
    while (t != 0) begin
      term = t / (2 * k + 1);
      if (k & 1) sum -= term; else sum += term;
      t /= m2;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned atan_pow2(int i);
    longint unsigned sum, term;
    int k, e;
    sum = 0; k = 0; e = 60 - i;
    while (e >= 0) begin
      term = (64'd1 << e) / longint'(2 * k + 1);
      if (k & 1) sum -= term; else sum += term;
      k++;
      e = 60 - i * (2 * k + 1);
    end
    return sum;
  endfunction

  function automatic void build_atan();
    longint unsigned q;
    q = 4 * atan_recip(5) - atan_recip(239);
    atan_z[0] = round_z(q);
    for (int i = 1; i < 30; i++) atan_z[i] = round_z(atan_pow2(i));
    pi_z      = round_z(4 * q);
    half_pi_z = round_z(2 * q);
  endfunction

  function automatic longint unsigned abs_diff(longint signed p, longint signed q);
    return (p >= q) ? longint'(p - q) : longint'(q - p);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // angle via atan2(|a x b|, a.b) with CORDIC vectoring
  function automatic angle_t predict_angle(pair_t p);
    angle_t r;
    longint signed ax, ay, az, bx, by, bz, x, y, z, xs, ys;
    longint signed prod[3];
    longint unsigned pos, neg, v[4], m, sq;
    bit dneg;
    ax = p.ax; ay = p.ay; az = p.az; bx = p.bx; by = p.by; bz = p.bz;
    r.angle = '0; r.zero_len = 1'b0;
    if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
      r.zero_len = 1'b1;
      return r;
    end
    prod[0] = ax * bx; prod[1] = ay * by; prod[2] = az * bz;
    pos = 0; neg = 0;
    for (int i = 0; i < 3; i++)
      if (prod[i] >= 0) pos += prod[i]; else neg += -prod[i];
    dneg = neg > pos;
    v[0] = dneg ? neg - pos : pos - neg;
    v[1] = abs_diff(ay * bz, az * by);
    v[2] = abs_diff(az * bx, ax * bz);
    v[3] = abs_diff(ax * by, ay * bx);
    m = 0;
    for (int i = 0; i < 4; i++) if (v[i] > m) m = v[i];
    if (m == 0) return r;
    // normalize so the largest magnitude sits in [2^29, 2^30)
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 4; i++) v[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 4; i++) v[i] <<= 1;
      m <<= 1;
    end
    sq = v[1] * v[1] + v[2] * v[2] + v[3] * v[3];
    if (dneg) begin
      x = floor_sqrt(sq); y = v[0]; z = half_pi_z;
    end else begin
      x = v[0]; y = floor_sqrt(sq); z = 0;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_z[i];
      end else begin
        x -= ys; y += xs; z -= atan_z[i];
      end
    end
    if (z < 0) z = 0;
    if (z > pi_z) z = pi_z;
    r.angle = (AFB+2)'((longint'(z) + (64'd1 << (29 - AFB))) >> (30 - AFB));
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0:       return CW'($urandom);
      1:       return CW'($signed($urandom_range(0, 64)) - 32);
      default: return ($urandom_range(0, 1)) ? CMAX : CMIN;
    endcase
  endfunction

  function automatic pair_t make_pair(logic signed [CW-1:0] ax, ay, az, bx, by, bz);
    pair_t p;
    p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
    return p;
  endfunction

  // clock, reset, stimulus and end of run
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    pair_t p;
    int sel, k, md;
    rst_n = 1'b0;
    build_atan();
    // directed: zero vectors, parallel, antiparallel, extremes, orthogonal
    pair_q.push_back(make_pair(0, 0, 0, 1, 2, 3));
    pair_q.push_back(make_pair(5, -7, 9, 0, 0, 0));
    pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pair_q.push_back(make_pair(1, 2, 3, 2, 4, 6));
    pair_q.push_back(make_pair(1, 2, 3, -2, -4, -6));
    pair_q.push_back(make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    pair_q.push_back(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    pair_q.push_back(make_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    pair_q.push_back(make_pair(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
    pair_q.push_back(make_pair(CMIN, 0, 0, 0, CMIN, 0));
    pair_q.push_back(make_pair(1, 0, 0, 0, 0, 1));
    pair_q.push_back(make_pair(1, 0, 0, -1, 0, 0));
    pair_q.push_back(make_pair(-1, -1, -1, -1, -1, -1));
    pair_q.push_back(make_pair(1, 0, 0, -1, 1, 0));
    pair_q.push_back(make_pair(1, 0, 0, 1, 1, 0));
    pair_q.push_back(make_pair(CMAX, 1, 0, 1, CMAX, 0));
    pair_q.push_back(make_pair(CMIN, 1, -1, CMAX, 0, 1));
    pair_q.push_back(make_pair(1, 0, 0, CMIN, 1, 0));
    for (int i = 0; i < N_RAND; i++) begin
      sel = $urandom_range(0, 99);
      md  = (sel < 60) ? 0 : (sel < 85) ? 1 : 2;
      p = make_pair(rand_coord(md), rand_coord(md), rand_coord(md),
                    rand_coord(md), rand_coord(md), rand_coord(md));
      if (sel % 10 == 0) begin
        // parallel or antiparallel multiple of a small vector
        k = $signed($urandom_range(0, 200)) - 100;
        p.ax = rand_coord(1); p.ay = rand_coord(1); p.az = rand_coord(1);
        p.bx = CW'(p.ax * k); p.by = CW'(p.ay * k); p.bz = CW'(p.az * k);
      end else if (sel % 17 == 0) begin
        if (sel & 1) begin
          p.ax = 0; p.ay = 0; p.az = 0;
        end else begin
          p.bx = 0; p.by = 0; p.bz = 0;
        end
      end
      pair_q.push_back(p);
    end
    n_total = pair_q.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (n_sent == n_total && !in_valid && angle_exp_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (n_mismatch == 0 && angle_exp_q.size() == 0) begin
      $display("[vector_angle_3d] OK");
    end else begin
      $display("[vector_angle_3d] ERROR");
    end
    $finish;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[vector_angle_3d] ERROR");
      $finish;
    end
  end

  initial begin
    cycles = 0; n_sent = 0; n_mismatch = 0; calm = 1'b0;
    in_valid = 1'b0; out_stall = 1'b0;
    a_x = '0; a_y = '0; a_z = '0; b_x = '0; b_y = '0; b_z = '0;
  end

  // driver: presents pairs from the queue, idles in random bursts
  int in_gap;
  initial in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        angle_exp_q.push_back(predict_angle(make_pair(a_x, a_y, a_z, b_x, b_y, b_z)));
        n_sent++;
        calm = n_sent > (n_total * 85) / 100;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
          in_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (pair_q.size() > 0) begin
          pair_t p;
          p = pair_q.pop_front();
          in_valid <= 1'b1;
          a_x <= p.ax; a_y <= p.ay; a_z <= p.az;
          b_x <= p.bx; b_y <= p.by; b_z <= p.bz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each output transfer against the oldest prediction
  int out_gap;
  initial out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (angle_exp_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected transfer: angle %0d zl %0b",
                                         angle, zero_length);
        end else begin
          angle_t e;
          e = angle_exp_q.pop_front();
          if (angle !== e.angle || zero_length !== e.zero_len) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: angle exp %0d got %0d, zl exp %0b got %0b",
                       e.angle, angle, e.zero_len, zero_length);
          end
        end
      end
      // random output stall bursts, none in the final stretch
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= (out_gap != 0);
      end else if (!calm && $urandom_range(0, 14) == 0) begin
        out_gap = $urandom_range(1, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

endmodule
